// ===== sv/pbb_pkg.sv =====
`default_nettype none
package pbb_pkg;

   // default sizing
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 4;
   localparam int MAX_HEIGHT_DEF = 4096;

   // register reset values
   localparam logic [10:0] WIDTH_RST  = 11'd640;
   localparam logic [12:0] HEIGHT_RST = 13'd480;
   localparam logic [2:0]  RADIUS_RST = 3'd1;

   // quotient bits of the divider chain
   localparam int QW = 8;

   // register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   // input kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SUM   = 6'b000010,
      ST_FLUSH = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // floor(x/255) for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [17:0] t;
      t = 18'(x) + 18'(x[15:8]) + 18'd1;
      return t[15:8];
   endfunction

endpackage
`default_nettype wire

// ===== sv/pbb_div_cell.sv =====
`default_nettype none
module pbb_div_cell import pbb_pkg::*; #(
   parameter int DW  = 24,
   parameter int DVW = 16,
   parameter int BIT = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [DVW-1:0] divisor,
   input  wire logic           vld_in,
   input  wire logic [DW-1:0]  rem_in,
   input  wire logic [QW-1:0]  q_in,
   output logic                vld_out,
   output logic [DW-1:0]       rem_out,
   output logic [QW-1:0]       q_out
);
   logic [DW-1:0] shifted;
   logic          take;

   // one restoring step at this bit weight
   assign shifted = DW'(divisor) << BIT;
   assign take    = (rem_in >= shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out <= 1'b0;
      end else begin
         vld_out <= vld_in;
      end
      rem_out <= take ? (rem_in - shifted) : rem_in;
      q_out   <= take ? (q_in | (QW'(1) << BIT)) : q_in;
   end
endmodule
`default_nettype wire

// ===== sv/pbb_div.sv =====
`default_nettype none
module pbb_div import pbb_pkg::*; #(
   parameter int DW  = 24,
   parameter int DVW = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [DW-1:0]  dividend,
   input  wire logic [DVW-1:0] divisor,
   output logic                done,
   output logic [QW-1:0]       quotient
);
   logic [DW-1:0] rem_w [QW+1];
   logic [QW-1:0] q_w   [QW+1];
   logic          v_w   [QW+1];

   assign rem_w[0] = dividend;
   assign q_w[0]   = '0;
   assign v_w[0]   = start;

   // chain of cells, most significant quotient bit first
   for (genvar i = 0; i < QW; i++) begin : g_cell
      pbb_div_cell #(.DW(DW), .DVW(DVW), .BIT(QW-1-i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .divisor (divisor),
         .vld_in  (v_w[i]),
         .rem_in  (rem_w[i]),
         .q_in    (q_w[i]),
         .vld_out (v_w[i+1]),
         .rem_out (rem_w[i+1]),
         .q_out   (q_w[i+1])
      );
   end

   assign done     = v_w[QW];
   assign quotient = q_w[QW];
endmodule
`default_nettype wire

// ===== sv/premultiplied_rgba_box_blur_unit.sv =====
`default_nettype none
// Premultiplied ARGB box blur over a raster pixel stream.
// req channel: one item per pixel (tuser 0) or drain tick (tuser 1); tdata
// carries alpha, red, green, blue from the low byte up. rsp channel: one
// blurred pixel per result, tlast on the final pixel of the frame.
// csr port: image_width at 0x0, image_height at 0x4, kernel_radius at 0x8;
// writing any of them restarts the frame. Write only while idle.
// An item that yields a result makes one line-store read per window
// position, then passes the 8-cell divider chains. Items without a result
// leave the block idle. The line store has a single read port, which sets
// the window sweep length. The result waits in an output register; a new
// item is accepted while it waits, and a stalled receiver holds the block
// only once the next result is ready. Results start R*W+R pixels after
// the first pixel; drain ticks push out the remaining ones.
// Reset restores register defaults, clears input and output positions; the
// line store is not cleared (every entry is written before it is read).
module premultiplied_rgba_box_blur_unit import pbb_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // in_alpha, in_red, in_green, in_blue
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_alpha, out_red, out_green, out_blue
   output logic             rsp_tlast,   // frame_last
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int RING = 2*MAX_RADIUS + 2;
   localparam int RGW  = $clog2(RING);
   localparam int CLW  = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int RDW  = $clog2(MAX_RADIUS + 1);
   localparam int KW   = $clog2(2*MAX_RADIUS + 1);
   localparam int SUMW = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*255 + 1);
   localparam int DW   = SUMW + 8;
   localparam int PW   = $clog2(MAX_WIDTH*MAX_HEIGHT + 1);

   // configuration
   logic [10:0] width_raw_ff;
   logic [12:0] height_raw_ff;
   logic [2:0]  radius_raw_ff;
   logic        cfg_wr;
   logic        cfg_hit;
   logic [WW-1:0]  eff_w;
   logic [HW-1:0]  eff_h;
   logic [RDW-1:0] eff_r;
   logic [KW-1:0]  span;
   logic [PW-1:0]  lag;
   logic [SUMW-1:0] area;

   // positions
   logic [CLW-1:0] in_col_ff, out_col_ff, wx_ff;
   logic [HW-1:0]  in_row_ff, out_row_ff, wy_ff;
   logic [RGW-1:0] in_ring_ff, out_ring_ff, wring_ff;
   logic [PW-1:0]  pin_ff;
   logic           frame_done_ff;
   logic           wlast_ff;
   logic [KW-1:0]  dy_ff, dx_ff;
   state_type      state_ff;

   // line store
   logic [31:0] mem [RING][MAX_WIDTH];
   logic [31:0] mem_q_ff;
   logic        rd_en_ff;
   logic [SUMW-1:0] sa_ff, sr_ff, sg_ff, sb_ff;

   logic        accept, is_drain, do_emit, do_write, out_last;
   logic [31:0] px_word;
   logic signed [HW+1:0] ypos;
   logic signed [WW+1:0] xpos;
   logic        in_win;
   logic [RGW+1:0] ring_t;
   logic [RGW-1:0] rd_ring;

   logic        div_start;
   logic        div_done_a, div_done_r, div_done_g, div_done_b;
   logic [QW-1:0] q_a, q_r, q_g, q_b;
   logic [31:0] rsp_tdata_ff;
   logic        rsp_tvalid_ff, rsp_tlast_ff;
   logic        rsp_free;

   // csr access
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // only writes to an existing register restart the frame
   assign cfg_hit = cfg_wr & ((csr_paddr[3:2] == REG_WIDTH) ||
                              (csr_paddr[3:2] == REG_HEIGHT) ||
                              (csr_paddr[3:2] == REG_RADIUS));

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = 32'(width_raw_ff);
         REG_HEIGHT: csr_prdata = 32'(height_raw_ff);
         REG_RADIUS: csr_prdata = 32'(radius_raw_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= WIDTH_RST;
         height_raw_ff <= HEIGHT_RST;
         radius_raw_ff <= RADIUS_RST;
      end else if (cfg_wr) begin
         if (csr_paddr[3:2] == REG_WIDTH)  width_raw_ff  <= csr_pwdata[10:0];
         if (csr_paddr[3:2] == REG_HEIGHT) height_raw_ff <= csr_pwdata[12:0];
         if (csr_paddr[3:2] == REG_RADIUS) radius_raw_ff <= csr_pwdata[2:0];
      end
   end

   // saturated working values, zero taken as one
   always_comb begin
      if (width_raw_ff == '0)                 eff_w = WW'(1);
      else if (int'(width_raw_ff) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
      else                                     eff_w = WW'(width_raw_ff);
      if (height_raw_ff == '0)                  eff_h = HW'(1);
      else if (int'(height_raw_ff) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
      else                                       eff_h = HW'(height_raw_ff);
      if (radius_raw_ff == '0)                  eff_r = RDW'(1);
      else if (int'(radius_raw_ff) > MAX_RADIUS) eff_r = RDW'(MAX_RADIUS);
      else                                       eff_r = RDW'(radius_raw_ff);
   end

   assign span = KW'(2*int'(eff_r));
   assign lag  = PW'(int'(eff_r) * int'(eff_w) + int'(eff_r));
   assign area = SUMW'((2*int'(eff_r)+1) * (2*int'(eff_r)+1));

   // input decode
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign is_drain   = (req_tuser == KIND_DRAIN);
   assign do_write   = accept & !is_drain & !frame_done_ff;
   assign do_emit    = accept & (is_drain ? frame_done_ff : (!frame_done_ff && pin_ff >= lag));
   assign out_last   = (int'(out_row_ff) == int'(eff_h) - 1) &&
                       (int'(out_col_ff) == int'(eff_w) - 1);
   assign px_word = {req_tdata[7:0],
                     div255(16'(req_tdata[15:8])  * 16'(req_tdata[7:0])),
                     div255(16'(req_tdata[23:16]) * 16'(req_tdata[7:0])),
                     div255(16'(req_tdata[31:24]) * 16'(req_tdata[7:0]))};

   // window position being read
   assign ypos = (HW+2)'(wy_ff) + (HW+2)'(dy_ff) - (HW+2)'(eff_r);
   assign xpos = (WW+2)'(wx_ff) + (WW+2)'(dx_ff) - (WW+2)'(eff_r);
   assign in_win = !ypos[HW+1] && (ypos < $signed({2'b00, eff_h})) &&
                   !xpos[WW+1] && (xpos < $signed({2'b00, eff_w}));
   assign ring_t = (RGW+2)'(wring_ff) + (RGW+2)'(dy_ff) + (RGW+2)'(RING) - (RGW+2)'(eff_r);
   always_comb begin
      if (int'(ring_t) >= 2*RING)  rd_ring = RGW'(int'(ring_t) - 2*RING);
      else if (int'(ring_t) >= RING) rd_ring = RGW'(int'(ring_t) - RING);
      else                           rd_ring = RGW'(ring_t);
   end

   // line store: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_write) mem[in_ring_ff][in_col_ff] <= px_word;
      mem_q_ff <= mem[rd_ring][xpos[CLW-1:0]];
   end

   // sequencer and frame positions
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_ring_ff    <= '0;
         pin_ff        <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_ring_ff   <= '0;
         frame_done_ff <= 1'b0;
         rd_en_ff      <= 1'b0;
      end else begin
         rd_en_ff <= (state_ff == ST_SUM) && in_win;
         if (cfg_hit) begin
            in_col_ff     <= '0;
            in_row_ff     <= '0;
            in_ring_ff    <= '0;
            pin_ff        <= '0;
            out_col_ff    <= '0;
            out_row_ff    <= '0;
            out_ring_ff   <= '0;
            frame_done_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (do_write) begin
                  pin_ff <= pin_ff + PW'(1);
                  if (int'(in_col_ff) + 1 >= int'(eff_w)) begin
                     in_col_ff  <= '0;
                     in_ring_ff <= (int'(in_ring_ff) == RING-1) ? '0 : in_ring_ff + RGW'(1);
                     if (int'(in_row_ff) + 1 >= int'(eff_h)) begin
                        in_row_ff     <= '0;
                        in_ring_ff    <= '0;
                        pin_ff        <= '0;
                        frame_done_ff <= 1'b1;
                     end else begin
                        in_row_ff <= in_row_ff + HW'(1);
                     end
                  end else begin
                     in_col_ff <= in_col_ff + CLW'(1);
                  end
               end
               if (do_emit) begin
                  state_ff <= ST_SUM;
                  wx_ff    <= out_col_ff;
                  wy_ff    <= out_row_ff;
                  wring_ff <= out_ring_ff;
                  wlast_ff <= out_last;
                  dy_ff    <= '0;
                  dx_ff    <= '0;
                  if (out_last) begin
                     out_col_ff    <= '0;
                     out_row_ff    <= '0;
                     out_ring_ff   <= '0;
                     frame_done_ff <= 1'b0;
                  end else if (int'(out_col_ff) + 1 >= int'(eff_w)) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + HW'(1);
                     out_ring_ff <= (int'(out_ring_ff) == RING-1) ? '0 : out_ring_ff + RGW'(1);
                  end else begin
                     out_col_ff <= out_col_ff + CLW'(1);
                  end
               end
            end
            ST_SUM: begin
               if (dx_ff == span) begin
                  dx_ff <= '0;
                  dy_ff <= dy_ff + KW'(1);
                  if (dy_ff == span) state_ff <= ST_FLUSH;
               end else begin
                  dx_ff <= dx_ff + KW'(1);
               end
            end
            ST_FLUSH: state_ff <= ST_LOAD;
            ST_LOAD:  state_ff <= ST_DIV;
            ST_DIV:   if (div_done_a) state_ff <= ST_OUT;
            ST_OUT:   if (rsp_free) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // window accumulators
   always_ff @(posedge clock) begin
      if (do_emit) begin
         sa_ff <= '0;
         sr_ff <= '0;
         sg_ff <= '0;
         sb_ff <= '0;
      end else if (rd_en_ff) begin
         sa_ff <= sa_ff + SUMW'(mem_q_ff[31:24]);
         sr_ff <= sr_ff + SUMW'(mem_q_ff[23:16]);
         sg_ff <= sg_ff + SUMW'(mem_q_ff[15:8]);
         sb_ff <= sb_ff + SUMW'(mem_q_ff[7:0]);
      end
   end

   // divider chains
   assign div_start = (state_ff == ST_LOAD);

   pbb_div #(.DW(DW), .DVW(SUMW)) u_div_a (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(DW'(sa_ff)), .divisor(area),
      .done(div_done_a), .quotient(q_a));
   pbb_div #(.DW(DW), .DVW(SUMW)) u_div_r (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend((DW'(sr_ff) << 8) - DW'(sr_ff)), .divisor(sa_ff),
      .done(div_done_r), .quotient(q_r));
   pbb_div #(.DW(DW), .DVW(SUMW)) u_div_g (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend((DW'(sg_ff) << 8) - DW'(sg_ff)), .divisor(sa_ff),
      .done(div_done_g), .quotient(q_g));
   pbb_div #(.DW(DW), .DVW(SUMW)) u_div_b (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend((DW'(sb_ff) << 8) - DW'(sb_ff)), .divisor(sa_ff),
      .done(div_done_b), .quotient(q_b));

   // output register
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && rsp_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_tdata_ff <= (sa_ff == '0) ? {24'd0, q_a} : {q_b, q_g, q_r, q_a};
         rsp_tlast_ff <= wlast_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // checks
   a_chain_sync: assert property (@(posedge clock) disable iff (reset)
      div_done_a |-> (div_done_r && div_done_g && div_done_b && state_ff == ST_DIV))
      else $error("divider chains out of step");
   a_no_out_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff)
      else $error("result valid after reset");
   a_load_on_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_free) |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
      else $error("result not loaded");
endmodule
`default_nettype wire
